[rtl/four_wheel_pid_current_control_top_assert.svh]
// Assertion macros for the four-wheel PID current controller.
// Included by the top level; the macros expand to nothing under SYNTHESIS.
`ifndef FOUR_WHEEL_PID_CURRENT_CONTROL_TOP_ASSERT_SVH
`define FOUR_WHEEL_PID_CURRENT_CONTROL_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define FWPCC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fwpcc: same-cycle check failed");

`define FWPCC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fwpcc: next-cycle check failed");

`else

`define FWPCC_ASSERT_IMP(label, ante, cons)

`define FWPCC_ASSERT_NXT(label, ante, cons)

`endif

`endif

[rtl/fwpcc_pkg.sv]
// Shared widths, constants and types of the four-wheel PID current controller.
// Used by the lane, the merge stage and the top level; depends on nothing.
`timescale 1ns / 1ps

package fwpcc_pkg;

    localparam int WHEEL_COUNT = 4;

    localparam int RPM_W  = 16;
    localparam int GAIN_W = 24;
    localparam int ERR_W  = 17;
    localparam int DD_W   = 18;
    localparam int INT_W  = 25;
    localparam int ACC_W  = 26;
    localparam int CMD_W  = 14;
    localparam int ESC_W  = 14;

    localparam int PP_W  = GAIN_W + 1 + ERR_W;
    localparam int IP_W  = GAIN_W + 1 + INT_W;
    localparam int DP_W  = GAIN_W + 1 + DD_W;
    localparam int P3_W  = PP_W + 13;
    localparam int I3_W  = IP_W + 2;
    localparam int SUM_W = 64;

    localparam int FRAC_W     = 16;
    localparam int X_W        = 24;
    localparam int RECIP_W    = 25;
    localparam int Q_SHIFT    = 36;
    localparam int Q_W        = 13;
    localparam int ESC_RCP_W  = 24;
    localparam int ESC_SHIFT  = 24;

    localparam int LANE_STAGES = 9;
    localparam int LOOP_STAGES = 4;

    localparam int OFIFO_DEPTH = 4;
    localparam int PTR_W       = $clog2(OFIFO_DEPTH);
    localparam int PEND_W      = $clog2(OFIFO_DEPTH + 1);

    localparam int IN_TDATA_W  = 2 * WHEEL_COUNT * RPM_W;
    localparam int OUT_TDATA_W = ((WHEEL_COUNT * (CMD_W + ESC_W) + 7) / 8) * 8;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PROPORTIONAL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DERIVATIVE   = CFG_IDX_W'(2);

    localparam logic [GAIN_W-1:0] KP_RESET = GAIN_W'(32768);
    localparam logic [GAIN_W-1:0] KI_RESET = GAIN_W'(3277);
    localparam logic [GAIN_W-1:0] KD_RESET = GAIN_W'(0);

    localparam logic signed [12:0] P_SCALE  = 13'sd3000;
    localparam logic signed [2:0]  I_SCALE  = 3'sd3;
    localparam logic signed [20:0] D_SCALE  = 21'sd1000000;
    localparam logic signed [2:0]  INT_STEP = 3'sd3;

    localparam logic signed [SUM_W-1:0] SAT_POS = 64'sd983040000000;
    localparam logic signed [SUM_W-1:0] SAT_NEG = -64'sd983040000000;
    localparam logic signed [ACC_W-1:0] INT_POS = 26'sd10000000;
    localparam logic signed [ACC_W-1:0] INT_NEG = -26'sd10000000;

    localparam logic [SUM_W-FRAC_W-1:0] BIG_LIM = (SUM_W - FRAC_W)'(15003000);
    localparam logic [11:0]      DIV_K   = 12'd3000;
    localparam logic [X_W:0]     REM_LIM = (X_W + 1)'(3000);
    localparam logic [Q_W-1:0]   OUT_LIM = Q_W'(5000);

    localparam logic [63:0] RECIP_FULL = (64'd1 << Q_SHIFT) / 64'd3000;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
    localparam logic [63:0] ESC_RECIP_FULL =
        ((64'd1 << ESC_SHIFT) * 64'd512 + 64'd624) / 64'd625;
    localparam logic [ESC_RCP_W-1:0] ESC_RECIP = ESC_RCP_W'(ESC_RECIP_FULL);

    typedef struct packed {
        logic ld;
        logic upd;
    } fwpcc_ctl_t;

    typedef struct packed {
        logic signed [CMD_W-1:0] cmd;
        logic signed [ESC_W-1:0] esc;
    } fwpcc_res_t;

endpackage

[rtl/fwpcc_lane.sv]
// One wheel lane of the PID current controller: a nine-stage pipeline with the
// integral and previous-error state of its wheel. Depends on fwpcc_pkg.
`timescale 1ns / 1ps

module fwpcc_lane import fwpcc_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  fwpcc_ctl_t              ctl,
    input  logic signed [RPM_W-1:0] target,
    input  logic signed [RPM_W-1:0] measured,
    input  logic [GAIN_W-1:0]       kp,
    input  logic [GAIN_W-1:0]       ki,
    input  logic [GAIN_W-1:0]       kd,
    output fwpcc_res_t              res
);

    typedef struct packed {
        logic signed [ERR_W-1:0] e;
        logic signed [INT_W-1:0] ie;
        logic                    tz;
    } side_t;

    logic signed [ERR_W-1:0] prev_err_reg, prev_err_next;
    logic signed [INT_W-1:0] integ_reg, integ_next;

    side_t                   side_reg [1:4];
    side_t                   side_next [1:4];
    logic signed [DD_W-1:0]  dd1_reg, dd1_next;
    logic signed [PP_W-1:0]  pp2_reg, pp2_next;
    logic signed [IP_W-1:0]  ip2_reg, ip2_next;
    logic signed [DP_W-1:0]  dp2_reg, dp2_next;
    logic signed [P3_W-1:0]  p3_reg, p3_next;
    logic signed [I3_W-1:0]  i3_reg, i3_next;
    logic signed [SUM_W-1:0] d3_reg, d3_next;
    logic signed [SUM_W-1:0] sum4_reg, sum4_next;

    logic [X_W-1:0] x5_reg, x5_next, x6_reg, x6_next;
    logic           big5_reg, big5_next, big6_reg, big6_next;
    logic           neg5_reg, neg5_next, neg6_reg, neg6_next;
    logic           neg7_reg, neg7_next, neg8_reg, neg8_next;
    logic [Q_W-1:0] q6_reg, q6_next;
    logic [Q_W-1:0] mag7_reg, mag7_next;
    logic [Q_W-1:0] em8_reg, em8_next;
    logic signed [CMD_W-1:0] cmd8_reg, cmd8_next, cmd9_reg, cmd9_next;
    logic signed [ESC_W-1:0] esc9_reg, esc9_next;

    logic                    sat_up, sat_dn;
    logic signed [ACC_W-1:0] acc;
    logic signed [INT_W-1:0] acc_clamped;
    logic [SUM_W-1:0]        mag;
    logic [SUM_W-FRAC_W-1:0] xw;
    logic [X_W+RECIP_W-1:0]  qprod;
    logic [Q_W+11:0]         back;
    logic [X_W:0]            rem;
    logic [Q_W-1:0]          qfix;
    logic [Q_W+ESC_RCP_W-1:0] eprod;

    always_comb begin
        side_next[1].e  = ERR_W'(target) - ERR_W'(measured);
        side_next[1].tz = (target == '0);
        side_next[1].ie = side_next[1].tz ? '0 : integ_reg;
        dd1_next        = DD_W'(side_next[1].e) - DD_W'(prev_err_reg);
        prev_err_next   = ctl.ld ? side_next[1].e : prev_err_reg;

        pp2_next = $signed({1'b0, kp}) * side_reg[1].e;
        ip2_next = $signed({1'b0, ki}) * side_reg[1].ie;
        dp2_next = $signed({1'b0, kd}) * dd1_reg;
        side_next[2] = side_reg[1];

        p3_next = pp2_reg * P_SCALE;
        i3_next = ip2_reg * I_SCALE;
        d3_next = dp2_reg * D_SCALE;
        side_next[3] = side_reg[2];

        sum4_next = SUM_W'(p3_reg) + SUM_W'(i3_reg) + d3_reg;
        side_next[4] = side_reg[3];
    end

    // The integral write closes the per-wheel loop; the saturation test uses
    // the exact unclamped sum against the current limit scaled by the divisor.
    always_comb begin
        sat_up = (sum4_reg > SAT_POS) && (side_reg[4].e > 0);
        sat_dn = (sum4_reg < SAT_NEG) && (side_reg[4].e < 0);
        acc    = side_reg[4].ie + side_reg[4].e * INT_STEP;
        if (acc > INT_POS) begin
            acc_clamped = INT_W'(INT_POS);
        end else if (acc < INT_NEG) begin
            acc_clamped = INT_W'(INT_NEG);
        end else begin
            acc_clamped = INT_W'(acc);
        end
        integ_next = integ_reg;
        if (ctl.upd) begin
            if (!side_reg[4].tz && !sat_up && !sat_dn) begin
                integ_next = acc_clamped;
            end else begin
                integ_next = side_reg[4].ie;
            end
        end

        mag       = sum4_reg[SUM_W-1] ? SUM_W'(-sum4_reg) : SUM_W'(sum4_reg);
        xw        = mag[SUM_W-1:FRAC_W];
        big5_next = (xw >= BIG_LIM);
        x5_next   = xw[X_W-1:0];
        neg5_next = sum4_reg[SUM_W-1];
    end

    always_comb begin
        qprod     = x5_reg * RECIP;
        q6_next   = qprod[Q_SHIFT +: Q_W];
        x6_next   = x5_reg;
        big6_next = big5_reg;
        neg6_next = neg5_reg;

        back      = q6_reg * DIV_K;
        rem       = {1'b0, x6_reg} - back[X_W:0];
        qfix      = q6_reg + Q_W'(rem >= REM_LIM);
        mag7_next = big6_reg ? OUT_LIM : qfix;
        neg7_next = neg6_reg;

        eprod     = mag7_reg * ESC_RECIP;
        em8_next  = eprod[ESC_SHIFT +: Q_W];
        cmd8_next = neg7_reg ? -CMD_W'(mag7_reg) : CMD_W'(mag7_reg);
        neg8_next = neg7_reg;

        esc9_next = neg8_reg ? -ESC_W'(em8_reg) : ESC_W'(em8_reg);
        cmd9_next = cmd8_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg <= '0;
            integ_reg    <= '0;
        end else begin
            prev_err_reg <= prev_err_next;
            integ_reg    <= integ_next;
        end
    end

    always_ff @(posedge aclk) begin
        side_reg <= side_next;
        dd1_reg  <= dd1_next;
        pp2_reg  <= pp2_next;
        ip2_reg  <= ip2_next;
        dp2_reg  <= dp2_next;
        p3_reg   <= p3_next;
        i3_reg   <= i3_next;
        d3_reg   <= d3_next;
        sum4_reg <= sum4_next;
        x5_reg   <= x5_next;
        big5_reg <= big5_next;
        neg5_reg <= neg5_next;
        q6_reg   <= q6_next;
        x6_reg   <= x6_next;
        big6_reg <= big6_next;
        neg6_reg <= neg6_next;
        mag7_reg <= mag7_next;
        neg7_reg <= neg7_next;
        em8_reg  <= em8_next;
        cmd8_reg <= cmd8_next;
        neg8_reg <= neg8_next;
        esc9_reg <= esc9_next;
        cmd9_reg <= cmd9_next;
    end

    assign res.cmd = cmd9_reg;
    assign res.esc = esc9_reg;

endmodule

[rtl/fwpcc_merge.sv]
// Merge stage: packs the four lane results into one output word and queues it
// in a four-entry buffer toward the master port. Depends on fwpcc_pkg.
`timescale 1ns / 1ps

module fwpcc_merge import fwpcc_pkg::*; (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              wr_en,
    input  fwpcc_res_t [WHEEL_COUNT-1:0]      lane_res,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [OUT_TDATA_W-1:0]            m_tdata,
    output logic [PEND_W-1:0]                 fill_cnt
);

    logic [OUT_TDATA_W-1:0] word;
    logic [OUT_TDATA_W-1:0] slot_reg [OFIFO_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [PEND_W-1:0]      cnt_reg, cnt_next;
    logic                   rd_en;

    always_comb begin
        word = '0;
        for (int w = 0; w < WHEEL_COUNT; w++) begin
            word[w*CMD_W +: CMD_W] = lane_res[w].cmd;
            word[WHEEL_COUNT*CMD_W + w*ESC_W +: ESC_W] = lane_res[w].esc;
        end
    end

    assign rd_en       = m_tvalid && m_tready;
    assign wr_ptr_next = wr_en ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
    assign rd_ptr_next = rd_en ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
    assign cnt_next    = cnt_reg + PEND_W'(wr_en) - PEND_W'(rd_en);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_reg[wr_ptr_reg] <= word;
        end
    end

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = slot_reg[rd_ptr_reg];
    assign fill_cnt = cnt_reg;

endmodule

[rtl/four_wheel_pid_current_control_top.sv]
// Four-wheel PID current controller, top level: four lanes plus a merge queue.
// m_tvalid rises once an accepted word has passed the lanes into the merge queue.
// A new word waits until the last has left the per-wheel integral loop (four lane
// stages from input to integral write-back); up to four results queue.
// Reset (aresetn, synchronous, active low) restores default gains and clears
// integrals, previous errors and the output queue. Depends on fwpcc_pkg.
`timescale 1ns / 1ps
`include "four_wheel_pid_current_control_top_assert.svh"

module four_wheel_pid_current_control_top import fwpcc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // target fl, fr, rl, rr, then measured fl, fr, rl, rr; 16 bits each
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // command fl, fr, rl, rr, then esc code fl, fr, rl, rr; 14 bits each
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [GAIN_W-1:0]      cfg_data
);

    logic [GAIN_W-1:0] kp_reg, kp_next;
    logic [GAIN_W-1:0] ki_reg, ki_next;
    logic [GAIN_W-1:0] kd_reg, kd_next;
    logic [LANE_STAGES:1] vld_reg, vld_next;
    logic [PEND_W-1:0] pending_reg, pending_next;
    logic [PEND_W-1:0] fill;
    logic s_acc, m_acc, loop_free;
    fwpcc_ctl_t ctl;
    fwpcc_res_t [WHEEL_COUNT-1:0] lane_res;

    assign cfg_ready = 1'b1;
    assign s_acc     = s_tvalid && s_tready;
    assign m_acc     = m_tvalid && m_tready;
    assign loop_free = (vld_reg[LOOP_STAGES:1] == '0);
    assign s_tready  = loop_free && (pending_reg != PEND_W'(OFIFO_DEPTH));

    always_comb begin
        kp_next = kp_reg;
        ki_next = ki_reg;
        kd_next = kd_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PROPORTIONAL: kp_next = cfg_data;
                REG_INTEGRAL:     ki_next = cfg_data;
                REG_DERIVATIVE:   kd_next = cfg_data;
                default: ;
            endcase
        end
        vld_next     = {vld_reg[LANE_STAGES-1:1], s_acc};
        pending_next = pending_reg + PEND_W'(s_acc) - PEND_W'(m_acc);
        ctl.ld       = s_acc;
        ctl.upd      = vld_reg[LOOP_STAGES];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg      <= KP_RESET;
            ki_reg      <= KI_RESET;
            kd_reg      <= KD_RESET;
            vld_reg     <= '0;
            pending_reg <= '0;
        end else begin
            kp_reg      <= kp_next;
            ki_reg      <= ki_next;
            kd_reg      <= kd_next;
            vld_reg     <= vld_next;
            pending_reg <= pending_next;
        end
    end

    for (genvar w = 0; w < WHEEL_COUNT; w++) begin : g_lane
        fwpcc_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .target   (s_tdata[w*RPM_W +: RPM_W]),
            .measured (s_tdata[(WHEEL_COUNT+w)*RPM_W +: RPM_W]),
            .kp       (kp_reg),
            .ki       (ki_reg),
            .kd       (kd_reg),
            .res      (lane_res[w])
        );
    end

    fwpcc_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (vld_reg[LANE_STAGES]),
        .lane_res (lane_res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .fill_cnt (fill)
    );

    `FWPCC_ASSERT_IMP(a_loop_one_word, 1'b1, $onehot0(vld_reg[LOOP_STAGES:1]))
    `FWPCC_ASSERT_IMP(a_credit_match, 1'b1, int'(pending_reg) == $countones(vld_reg) + int'(fill))
    `FWPCC_ASSERT_IMP(a_queue_room, vld_reg[LANE_STAGES], fill != PEND_W'(OFIFO_DEPTH))
    `FWPCC_ASSERT_NXT(a_loop_blocks, s_tvalid && s_tready, !s_tready)

endmodule

[tb/tb_four_wheel_pid_current_control_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the four-wheel PID current controller top level.
// Streams control ticks against a cycle-free predictor of the four lanes, writes
// the gain registers between phases, and depends on fwpcc_pkg and the RTL only.

module tb_four_wheel_pid_current_control_top;
    import fwpcc_pkg::*;

    localparam longint CURRENT_DIV      = 196608000;
    localparam longint CURRENT_MAX      = 5000;
    localparam longint INTEGRAL_MAX     = 10000000;
    localparam longint INTEGRAL_STEP    = 3;
    localparam longint P_WEIGHT         = 3000;
    localparam longint I_WEIGHT         = 3;
    localparam longint D_WEIGHT         = 1000000;
    localparam longint ESC_FULL_SCALE   = 16384;
    localparam longint ESC_CURRENT_SPAN = 20000;

    localparam logic [GAIN_W-1:0]    GAIN_MAX   = {GAIN_W{1'b1}};
    localparam logic [GAIN_W-1:0]    GAIN_UNITY = GAIN_W'(65536);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

    localparam int RPM_MAX       = 32767;
    localparam int RPM_MIN       = -32768;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 100;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [GAIN_W-1:0]      cfg_data;

    longint gain_p;
    longint gain_i;
    longint gain_d;
    longint integral_mem [WHEEL_COUNT];
    longint last_error [WHEEL_COUNT];

    logic [OUT_TDATA_W-1:0] pending_currents [$];
    int tick_target [WHEEL_COUNT];
    int tick_measured [WHEEL_COUNT];
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int error_count = 0;
    int stall_cycles = 0;

    four_wheel_pid_current_control_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    task automatic reset_model;
        gain_p = KP_RESET;
        gain_i = KI_RESET;
        gain_d = KD_RESET;
        for (int w = 0; w < WHEEL_COUNT; w++) begin
            integral_mem[w] = 0;
            last_error[w] = 0;
            tick_target[w] = 0;
            tick_measured[w] = 0;
        end
    endtask

    // Advances the lane state by one tick and returns the packed currents and ESC codes.
    function automatic logic [OUT_TDATA_W-1:0] predict_currents(
        input logic [IN_TDATA_W-1:0] word
    );
        logic signed [RPM_W-1:0] t16;
        logic signed [RPM_W-1:0] m16;
        longint tgt;
        longint meas;
        longint err;
        longint dd;
        longint integ;
        longint acc;
        longint cmd;
        longint esc;
        logic up;
        logic dn;
        logic [OUT_TDATA_W-1:0] res;
        res = '0;
        for (int w = 0; w < WHEEL_COUNT; w++) begin
            t16 = word[w*RPM_W +: RPM_W];
            m16 = word[(WHEEL_COUNT+w)*RPM_W +: RPM_W];
            tgt = t16;
            meas = m16;
            err = tgt - meas;
            dd = err - last_error[w];
            last_error[w] = err;
            if (tgt == 0) begin
                integral_mem[w] = 0;
            end
            integ = integral_mem[w];
            acc = P_WEIGHT * gain_p * err + I_WEIGHT * gain_i * integ + D_WEIGHT * gain_d * dd;
            cmd = acc / CURRENT_DIV;
            if (cmd > CURRENT_MAX) begin
                cmd = CURRENT_MAX;
            end else if (cmd < -CURRENT_MAX) begin
                cmd = -CURRENT_MAX;
            end
            if (tgt != 0) begin
                up = (acc > CURRENT_MAX * CURRENT_DIV) && (err > 0);
                dn = (acc < -CURRENT_MAX * CURRENT_DIV) && (err < 0);
                if (!up && !dn) begin
                    integ = integ + err * INTEGRAL_STEP;
                    if (integ > INTEGRAL_MAX) begin
                        integ = INTEGRAL_MAX;
                    end else if (integ < -INTEGRAL_MAX) begin
                        integ = -INTEGRAL_MAX;
                    end
                    integral_mem[w] = integ;
                end
            end
            esc = cmd * ESC_FULL_SCALE / ESC_CURRENT_SPAN;
            res[w*CMD_W +: CMD_W] = cmd[CMD_W-1:0];
            res[WHEEL_COUNT*CMD_W + w*ESC_W +: ESC_W] = esc[ESC_W-1:0];
        end
        return res;
    endfunction

    function automatic int random_rpm();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int clamp_rpm(input int v);
        if (v > RPM_MAX) begin
            return RPM_MAX;
        end else if (v < RPM_MIN) begin
            return RPM_MIN;
        end
        return v;
    endfunction

    function automatic int random_target();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
            return 0;
        end else if (pick < 3) begin
            return random_rpm();
        end
        return int'($urandom_range(0, 6000)) - 3000;
    endfunction

    // Sends the word held in tick_target and tick_measured and records its prediction.
    task automatic send_tick;
        logic [IN_TDATA_W-1:0] word;
        for (int w = 0; w < WHEEL_COUNT; w++) begin
            word[w*RPM_W +: RPM_W] = tick_target[w][RPM_W-1:0];
            word[(WHEEL_COUNT+w)*RPM_W +: RPM_W] = tick_measured[w][RPM_W-1:0];
        end
        s_tdata <= word;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_currents.push_back(predict_currents(word));
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic drive_lanes(input int t0, input int t1, input int t2, input int t3,
                               input int m0, input int m1, input int m2, input int m3);
        tick_target[0] = t0;
        tick_target[1] = t1;
        tick_target[2] = t2;
        tick_target[3] = t3;
        tick_measured[0] = m0;
        tick_measured[1] = m1;
        tick_measured[2] = m2;
        tick_measured[3] = m3;
        send_tick();
    endtask

    task automatic drain_results;
        s_tvalid <= 1'b0;
        while (pending_currents.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PROPORTIONAL: gain_p = val;
            REG_INTEGRAL:     gain_i = val;
            REG_DERIVATIVE:   gain_d = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic load_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                              input logic [GAIN_W-1:0] kd);
        drain_results();
        write_gain(REG_PROPORTIONAL, kp);
        write_gain(REG_INTEGRAL, ki);
        write_gain(REG_DERIVATIVE, kd);
    endtask

    task automatic test_reset_defaults;
        drive_lanes(0, 0, 0, 0, 0, 0, 0, 0);
        drive_lanes(RPM_MAX, RPM_MAX, RPM_MAX, RPM_MAX, RPM_MIN, RPM_MIN, RPM_MIN, RPM_MIN);
        drive_lanes(RPM_MIN, RPM_MIN, RPM_MIN, RPM_MIN, RPM_MAX, RPM_MAX, RPM_MAX, RPM_MAX);
        drive_lanes(0, 0, 0, 0, 1000, -1000, RPM_MAX, RPM_MIN);
        drive_lanes(1234, -1234, RPM_MAX, RPM_MIN, 1234, -1234, RPM_MAX, RPM_MIN);
        drive_lanes(100, -100, 3000, -3000, 90, -90, 0, 0);
        drive_lanes(100, -100, 3000, -3000, 90, -90, 0, 0);
        drive_lanes(9999, -10001, 10001, -9999, 0, 0, 0, 0);
    endtask

    task automatic test_gain_writes;
        load_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX);
        drive_lanes(RPM_MAX, RPM_MAX, RPM_MAX, RPM_MAX, RPM_MIN, RPM_MIN, RPM_MIN, RPM_MIN);
        drive_lanes(RPM_MIN, RPM_MIN, RPM_MIN, RPM_MIN, RPM_MAX, RPM_MAX, RPM_MAX, RPM_MAX);
        drive_lanes(0, 0, 0, 0, RPM_MIN, RPM_MAX, 1, -1);
        // A write to the spare index must leave every gain alone.
        drain_results();
        write_gain(REG_UNUSED, GAIN_MAX);
        drive_lanes(5, -5, 77, -77, 0, 0, 0, 0);
        load_gains('0, '0, '0);
        drive_lanes(RPM_MAX, RPM_MIN, 1, -1, RPM_MIN, RPM_MAX, -1, 1);
        drive_lanes(RPM_MIN, RPM_MAX, -1, 1, RPM_MAX, RPM_MIN, 1, -1);
        load_gains(KP_RESET, KI_RESET, KD_RESET);
    endtask

    task automatic test_esc_scaling;
        // With unity proportional gain and nothing else, the command equals the error within the +/-5000 limit.
        load_gains(GAIN_UNITY, '0, '0);
        drive_lanes(1, -1, 1221, -1222, 0, 0, 0, 0);
        drive_lanes(4999, -4999, 5000, -5000, 0, 0, 0, 0);
        drive_lanes(5001, -5001, RPM_MAX, RPM_MIN, 0, 0, 0, 0);
        drive_lanes(25, -25, 2442, -2443, 0, 0, 0, 0);
        drive_lanes(1, 1, 1, 1, 0, 1, 2, -4999);
    endtask

    task automatic pick_wide_error(input int w);
        if ($urandom_range(0, 5) == 0) begin
            tick_target[w] = 0;
            tick_measured[w] = random_rpm();
        end else if ($urandom_range(0, 1) == 0) begin
            tick_target[w] = $urandom_range(16384, 32767);
            tick_measured[w] = -int'($urandom_range(16384, 32768));
        end else begin
            tick_target[w] = -int'($urandom_range(16384, 32768));
            tick_measured[w] = $urandom_range(16384, 32767);
        end
    endtask

    // Long runs of held large errors drive the integrals into their limit or into
    // the directional hold, depending on how strong the integral gain is.
    task automatic test_integral_limit(input int n_items);
        int sent;
        int run;
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        sent = 0;
        while (sent < n_items) begin
            kp = ($urandom_range(0, 1) == 0) ? '0 : GAIN_W'($urandom_range(0, 4096));
            if ($urandom_range(0, 1) == 0) begin
                ki = GAIN_W'($urandom_range(1, 64));
            end else begin
                ki = GAIN_W'($urandom_range(20000, 200000));
            end
            load_gains(kp, ki, '0);
            for (int w = 0; w < WHEEL_COUNT; w++) begin
                pick_wide_error(w);
            end
            run = $urandom_range(60, 140);
            if (run > n_items - sent) begin
                run = n_items - sent;
            end
            repeat (run) begin
                for (int w = 0; w < WHEEL_COUNT; w++) begin
                    if ($urandom_range(0, 119) == 0) begin
                        pick_wide_error(w);
                    end
                end
                send_tick();
                sent++;
            end
        end
    endtask

    // Mostly closed-loop style tracking, with random words and edge words mixed in.
    task automatic test_random_control(input int n_items);
        int sent;
        int run;
        int pick;
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 5))
                0: begin
                    kp = KP_RESET;
                    ki = KI_RESET;
                    kd = KD_RESET;
                end
                1: begin
                    kp = GAIN_MAX;
                    ki = GAIN_MAX;
                    kd = GAIN_MAX;
                end
                2: begin
                    kp = '0;
                    ki = '0;
                    kd = '0;
                end
                3: begin
                    kp = GAIN_W'($urandom());
                    ki = GAIN_W'($urandom());
                    kd = GAIN_W'($urandom());
                end
                4: begin
                    kp = GAIN_W'($urandom_range(0, 131072));
                    ki = GAIN_W'($urandom_range(0, 16384));
                    kd = GAIN_W'($urandom_range(0, 255));
                end
                default: begin
                    kp = GAIN_W'($urandom_range(0, 131072));
                    ki = GAIN_MAX;
                    kd = GAIN_W'($urandom_range(0, 64));
                end
            endcase
            load_gains(kp, ki, kd);
            run = $urandom_range(30, 70);
            if (run > n_items - sent) begin
                run = n_items - sent;
            end
            repeat (run) begin
                pick = $urandom_range(0, 99);
                for (int w = 0; w < WHEEL_COUNT; w++) begin
                    if (pick < 70) begin
                        if ($urandom_range(0, 19) == 0) begin
                            tick_target[w] = random_target();
                        end
                        tick_measured[w] = clamp_rpm(tick_measured[w]
                            + (tick_target[w] - tick_measured[w]) / 4
                            + int'($urandom_range(0, 100)) - 50);
                    end else if (pick < 85) begin
                        tick_target[w] = random_rpm();
                        tick_measured[w] = random_rpm();
                    end else begin
                        case ($urandom_range(0, 4))
                            0: begin
                                tick_target[w] = 0;
                                tick_measured[w] = random_rpm();
                            end
                            1: begin
                                tick_target[w] = random_rpm();
                                tick_measured[w] = tick_target[w];
                            end
                            2: begin
                                tick_target[w] = RPM_MAX;
                                tick_measured[w] = RPM_MIN;
                            end
                            3: begin
                                tick_target[w] = RPM_MIN;
                                tick_measured[w] = RPM_MAX;
                            end
                            default: begin
                                tick_target[w] = 0;
                                tick_measured[w] = 0;
                            end
                        endcase
                    end
                end
                send_tick();
                sent++;
                if ($urandom_range(0, 149) == 0) begin
                    drain_results();
                end
            end
        end
    endtask

    always @(posedge aclk) begin : result_check
        logic [OUT_TDATA_W-1:0] want;
        logic signed [CMD_W-1:0] want_f;
        logic signed [CMD_W-1:0] got_f;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_currents.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT) begin
                    $display("%0t: result word %h with none expected", $time, m_tdata);
                end
            end else begin
                want = pending_currents.pop_front();
                for (int f = 0; f < 2 * WHEEL_COUNT; f++) begin
                    want_f = want[f*CMD_W +: CMD_W];
                    got_f = m_tdata[f*CMD_W +: CMD_W];
                    if (want_f !== got_f) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT) begin
                            $display("%0t: %s wheel %0d expected %0d actual %0d", $time,
                                     (f < WHEEL_COUNT) ? "command" : "esc_code",
                                     f % WHEEL_COUNT, want_f, got_f);
                        end
                    end
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb_four_wheel_pid_current_control_top: done, errors");
                $finish;
            end
        end
    end

    initial begin
        aresetn <= 1'b0;
        s_tdata <= '0;
        s_tvalid <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        reset_model();
        src_idle_pct = 30;
        sink_idle_pct = 53;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_gain_writes();
        test_esc_scaling();
        test_integral_limit(200);
        test_random_control(240);

        src_idle_pct = 53;
        sink_idle_pct = 30;
        test_integral_limit(200);
        test_random_control(240);

        src_idle_pct = 0;
        sink_idle_pct = 0;
        test_integral_limit(200);
        test_random_control(240);

        drain_results();
        if (error_count == 0) begin
            $display("tb_four_wheel_pid_current_control_top: done, clean");
        end else begin
            $display("tb_four_wheel_pid_current_control_top: done, errors");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/fwpcc_pkg.sv
rtl/fwpcc_lane.sv
rtl/fwpcc_merge.sv
rtl/four_wheel_pid_current_control_top.sv
tb/tb_four_wheel_pid_current_control_top.sv
